@@ rtl/core/gpfi_pkg.sv @@
package gpfi_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_B    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_LEN_RST = 11'd1024;
  localparam logic [CFG_W-1:0] STEP_B_RST    = 11'd641;
  localparam logic             MODE_RST      = 1'b0;

  // Per-cycle command from the sequencer to the frame memory and output stage.
  typedef struct packed {
    logic rd_en;
    logic rd_last;
    logic wr_en;
  } mem_cmd_t;

endpackage

@@ rtl/core/gpfi_step_mod.sv @@
module gpfi_step_mod
  import gpfi_pkg::*;
#(
  parameter int MAX_FRAME = 1024,
  localparam int LEN_W = $clog2(MAX_FRAME + 1),
  localparam int CNT_W = $clog2(MAX_FRAME)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CFG_W-1:0] step,
  input  logic [LEN_W-1:0] eff_n,
  output logic             busy,
  output logic [CNT_W-1:0] rem
);

  localparam int RST_N   = (MAX_FRAME < int'(FRAME_LEN_RST)) ? MAX_FRAME : int'(FRAME_LEN_RST);
  localparam int RST_REM = int'(STEP_B_RST) % RST_N;
  localparam int CBW     = $clog2(CFG_W + 1);

  logic             busy_r;
  logic [CBW-1:0]   cnt_r;
  logic [CFG_W-1:0] sh_r;
  logic [LEN_W-1:0] r_r;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   n_ext;
  logic [LEN_W:0]   trial_red;

  // One step of restoring division: bring in the next dividend bit and
  // subtract N if the partial remainder reaches it.
  always_comb begin
    trial     = {r_r, sh_r[CFG_W-1]};
    n_ext     = {1'b0, eff_n};
    trial_red = (trial >= n_ext) ? (trial - n_ext) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      r_r    <= LEN_W'(RST_REM);
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CBW'(CFG_W);
      r_r    <= '0;
      sh_r   <= step;
    end else if (busy_r) begin
      r_r   <= trial_red[LEN_W-1:0];
      sh_r  <= {sh_r[CFG_W-2:0], 1'b0};
      cnt_r <= cnt_r - CBW'(1);
      if (cnt_r == CBW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign rem  = r_r[CNT_W-1:0];

endmodule

@@ rtl/core/gpfi_seq.sv @@
module gpfi_seq
  import gpfi_pkg::*;
#(
  parameter int MAX_FRAME = 1024,
  localparam int LEN_W = $clog2(MAX_FRAME + 1),
  localparam int CNT_W = $clog2(MAX_FRAME),
  localparam int IDX_W = $clog2(2 * MAX_FRAME)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic             accept,
  input  logic             drain,
  input  logic             mode,
  input  logic [LEN_W-1:0] eff_n,
  input  logic [CNT_W-1:0] step,
  output logic             rd_full,
  output mem_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_idx,
  output logic [IDX_W-1:0] wr_idx
);

  logic [CNT_W-1:0] wc_r, wc_nxt;
  logic [CNT_W-1:0] wpa_r, wpa_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  logic [CNT_W-1:0] rpa_r, rpa_nxt;
  logic             wb_r, wb_nxt;
  logic             full_r, full_nxt;

  logic [CNT_W:0]   n_ext;
  logic             rd_last;
  logic             wr_last;
  logic [CNT_W:0]   rpa_sum, rpa_inc;
  logic [CNT_W:0]   wpa_sum, wpa_inc;
  logic [CNT_W-1:0] rd_addr;
  logic [CNT_W-1:0] wr_addr;

  always_comb begin
    n_ext   = (CNT_W+1)'(eff_n);
    rd_last = ({1'b0, rc_r} + (CNT_W+1)'(1)) >= n_ext;
    wr_last = ({1'b0, wc_r} + (CNT_W+1)'(1)) >= n_ext;
    // Running (b*i) mod N: the sum of two residues needs at most one subtract.
    rpa_sum = {1'b0, rpa_r} + {1'b0, step};
    rpa_inc = (rpa_sum >= n_ext) ? (rpa_sum - n_ext) : rpa_sum;
    wpa_sum = {1'b0, wpa_r} + {1'b0, step};
    wpa_inc = (wpa_sum >= n_ext) ? (wpa_sum - n_ext) : wpa_sum;

    wc_nxt   = wc_r;
    wpa_nxt  = wpa_r;
    rc_nxt   = rc_r;
    rpa_nxt  = rpa_r;
    wb_nxt   = wb_r;
    full_nxt = full_r;

    if (accept && full_r) begin
      if (rd_last) begin
        full_nxt = 1'b0;
        rc_nxt   = '0;
        rpa_nxt  = '0;
      end else begin
        rc_nxt  = rc_r + CNT_W'(1);
        rpa_nxt = rpa_inc[CNT_W-1:0];
      end
    end

    // A completed frame takes precedence over the read progress above.
    if (accept && !drain) begin
      if (wr_last) begin
        wc_nxt   = '0;
        wpa_nxt  = '0;
        wb_nxt   = ~wb_r;
        full_nxt = 1'b1;
        rc_nxt   = '0;
        rpa_nxt  = '0;
      end else begin
        wc_nxt  = wc_r + CNT_W'(1);
        wpa_nxt = wpa_inc[CNT_W-1:0];
      end
    end

    rd_addr = mode ? rpa_r : rc_r;
    wr_addr = mode ? wc_r : wpa_r;
    rd_idx  = wb_r ? IDX_W'(rd_addr) : (IDX_W'(MAX_FRAME) + IDX_W'(rd_addr));
    wr_idx  = wb_r ? (IDX_W'(MAX_FRAME) + IDX_W'(wr_addr)) : IDX_W'(wr_addr);

    cmd.rd_en   = accept && full_r;
    cmd.rd_last = rd_last;
    cmd.wr_en   = accept && !drain;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wc_r   <= '0;
      wpa_r  <= '0;
      rc_r   <= '0;
      rpa_r  <= '0;
      wb_r   <= 1'b0;
      full_r <= 1'b0;
    end else begin
      wc_r   <= wc_nxt;
      wpa_r  <= wpa_nxt;
      rc_r   <= rc_nxt;
      rpa_r  <= rpa_nxt;
      wb_r   <= wb_nxt;
      full_r <= full_nxt;
    end
  end

  assign rd_full = full_r;

endmodule

@@ rtl/core/gpfi_frame_mem.sv @@
module gpfi_frame_mem
  import gpfi_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 2048,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  mem_cmd_t              cmd,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [IDX_W-1:0]      rd_idx,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Reads and writes of one transaction always hit opposite banks, and a
  // write is committed at the edge before any later read samples the array.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/gpfi_out_skid.sv @@
module gpfi_out_skid
  import gpfi_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mem_cmd_t              cmd,
  input  logic [DATA_WIDTH-1:0] rd_data,
  output logic                  s1_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic                  out_last
);

  logic                  s1_vld_r;
  logic                  s1_last_r;
  logic                  s2_vld_r;
  logic [DATA_WIDTH-1:0] s2_data_r;
  logic                  s2_last_r;
  logic                  s1_adv;

  // Stage one is the memory read register; stage two is the output register.
  assign s1_adv  = s1_vld_r && (!s2_vld_r || out_ready);
  assign s1_free = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_r <= 1'b1;
      end else if (out_ready) begin
        s2_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      s1_last_r <= cmd.rd_last;
    end
    if (s1_adv) begin
      s2_data_r <= rd_data;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_data  = s2_data_r;
  assign out_last  = s2_last_r;

endmodule

@@ rtl/core/golden_prime_frame_interleaver_unit.sv @@
// Frame interleaver that permutes each frame of N elements by j = (b*i) mod N
// through a two-bank ping-pong frame memory; output runs one frame behind
// input. One transaction is taken per clock while the output side keeps up:
// the frame memory has one write and one read port, and reading from one bank
// while the other fills lets a read and a write happen in every cycle. A
// transaction with drain set stores nothing and only releases the next
// buffered element. Each result passes a memory read register and an output
// register. Every configuration write to frame_len, step_b or mode restarts
// the datapath, drops any buffered frame and then holds in_ready low while
// b mod N is recomputed by a bit-serial divider, one bit of step_b per cycle.
// The frame memory is not cleared; software must choose step_b coprime to
// frame_len.
module golden_prime_frame_interleaver_unit
  import gpfi_pkg::*;
#(
  parameter int MAX_FRAME  = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_data,
  input  logic                  in_drain,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int LEN_W = $clog2(MAX_FRAME + 1);
  localparam int CNT_W = $clog2(MAX_FRAME);
  localparam int IDX_W = $clog2(2 * MAX_FRAME);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [CFG_W-1:0] frame_len_r, frame_len_nxt;
  logic [CFG_W-1:0] step_b_r, step_b_nxt;
  logic             mode_r, mode_nxt;
  logic             cfg_hit;
  logic             mod_start_r;

  logic [CMP_W-1:0] fl_ext;
  logic [LEN_W-1:0] eff_n;
  logic [CNT_W-1:0] step_rem;
  logic             mod_busy;
  logic             rd_full;
  logic             s1_free;
  logic             in_fire;
  mem_cmd_t         cmd;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [DATA_WIDTH-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    frame_len_nxt = frame_len_r;
    step_b_nxt    = step_b_r;
    mode_nxt      = mode_r;
    cfg_hit       = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_LEN: begin
          frame_len_nxt = cfg_data;
          cfg_hit       = 1'b1;
        end
        REG_STEP_B: begin
          step_b_nxt = cfg_data;
          cfg_hit    = 1'b1;
        end
        REG_MODE: begin
          mode_nxt = cfg_data[0];
          cfg_hit  = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LEN_RST;
      step_b_r    <= STEP_B_RST;
      mode_r      <= MODE_RST;
      mod_start_r <= 1'b0;
    end else begin
      frame_len_r <= frame_len_nxt;
      step_b_r    <= step_b_nxt;
      mode_r      <= mode_nxt;
      mod_start_r <= cfg_hit;
    end
  end

  // Frame length of zero acts as one; lengths above the memory saturate.
  always_comb begin
    fl_ext = CMP_W'(frame_len_r);
    if (fl_ext == '0) begin
      eff_n = LEN_W'(1);
    end else if (fl_ext > CMP_W'(MAX_FRAME)) begin
      eff_n = LEN_W'(MAX_FRAME);
    end else begin
      eff_n = fl_ext[LEN_W-1:0];
    end
  end

  assign in_ready = !mod_start_r && !mod_busy && (!rd_full || s1_free);
  assign in_fire  = in_valid && in_ready;

  gpfi_step_mod #(
    .MAX_FRAME (MAX_FRAME)
  ) u_step_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start_r),
    .step  (step_b_r),
    .eff_n (eff_n),
    .busy  (mod_busy),
    .rem   (step_rem)
  );

  gpfi_seq #(
    .MAX_FRAME (MAX_FRAME)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_hit),
    .accept  (in_fire),
    .drain   (in_drain),
    .mode    (mode_r),
    .eff_n   (eff_n),
    .step    (step_rem),
    .rd_full (rd_full),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx)
  );

  gpfi_frame_mem #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (2 * MAX_FRAME)
  ) u_frame_mem (
    .clk     (clk),
    .cmd     (cmd),
    .wr_idx  (wr_idx),
    .wr_data (in_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  gpfi_out_skid #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_data   (rd_data),
    .s1_free   (s1_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_last  (out_last)
  );

`ifndef NO_ASSERTIONS
  // A read and a write in the same cycle must land in different banks.
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en && cmd.wr_en |-> rd_idx != wr_idx)
    else $error("read and write hit the same frame memory slot");

  // The memory read register is never refilled while it holds an unsent word.
  a_rd_reg_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> s1_free)
    else $error("frame memory read issued over a pending word");

  // A configuration write always leads into a divider pass.
  a_mod_runs: assert property (@(posedge clk) disable iff (!rst_n)
    mod_start_r |=> mod_busy)
    else $error("step divider did not start after a configuration write");
`endif

endmodule
